// ===== rtl/core/mtm_pkg.sv =====
// Shared types and codes for the timer table block.
// No dependencies; every other file in rtl/core except mtm_ram imports this package.
package mtm_pkg;

   // command codes carried in the request word
   localparam logic [2:0] CMD_START   = 3'd0;
   localparam logic [2:0] CMD_STOP    = 3'd1;
   localparam logic [2:0] CMD_RESTART = 3'd2;
   localparam logic [2:0] CMD_SETPER  = 3'd3;
   localparam logic [2:0] CMD_QUERY   = 3'd4;
   localparam logic [2:0] CMD_TICK    = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_CMD_DONE  = 2'd0;
   localparam logic [1:0] KIND_EXPIRY    = 2'd1;
   localparam logic [1:0] KIND_TICK_DONE = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;

   // most expiry words one tick may emit before its closing word
   localparam int MAX_EXPIRIES = 16;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] timer_id;
      logic [31:0] duration;
      logic        cyclic;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [1:0]  status;
      logic [15:0] event_timer_id;
      logic        event_cyclic;
      logic        is_active;
      logic        last_of_run;
   } rsp_word_type;

   // one queued command, tagged by the front end
   typedef struct packed {
      req_word_type word;
      logic         is_tick;
   } queue_entry_type;

   // one timer slot as stored in the slot memory
   typedef struct packed {
      logic [15:0] id;
      logic [31:0] duration;
      logic [32:0] elapsed;
      logic        periodic;
   } slot_type;

endpackage

// ===== rtl/core/mtm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/mtm_front.sv =====
// Front end: accepts request words, tags ticks, and holds them in a two-entry queue.
// Depends on mtm_pkg.
module mtm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mtm_pkg::req_word_type   req_word,
   output logic                    q_valid,
   output mtm_pkg::queue_entry_type q_entry,
   input  logic                    q_pop
);
   import mtm_pkg::*;

   queue_entry_type q_ff [2];
   logic            wp_ff, wp_in;
   logic            rp_ff, rp_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            push;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_entry = q_ff[rp_ff];

   // advance pointers and fill count
   always_comb begin
      wp_in  = push  ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the word with its tick tag
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff].word    <= req_word;
         q_ff[wp_ff].is_tick <= (req_word.command == CMD_TICK);
      end
   end
endmodule

// ===== rtl/core/mtm_back.sv =====
// Back end: scans the slot memory to carry out commands and ticks, and drives results.
// Depends on mtm_pkg and mtm_ram.
module mtm_back #(
   parameter int MAX_TIMERS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  mtm_pkg::queue_entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_strobe,
   output mtm_pkg::rsp_word_type    rsp_word
);
   import mtm_pkg::*;

   localparam int IW = $clog2(MAX_TIMERS > 1 ? MAX_TIMERS : 2);
   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam int SW = $bits(slot_type);
   localparam logic [CW-1:0] LAST_CNT = CW'(MAX_TIMERS);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOOK = 7'b0000010,
      ST_EXEC = 7'b0000100,
      ST_INC  = 7'b0001000,
      ST_SEL  = 7'b0010000,
      ST_FIRE = 7'b0100000,
      ST_TEND = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   dok_ff, dok_in;
   logic [IW-1:0]          didx_ff, didx_in;
   req_word_type           cmd_ff, cmd_in;
   logic [MAX_TIMERS-1:0]  valid_ff, valid_in;
   logic [MAX_TIMERS-1:0]  done_ff, done_in;
   logic                   match_ff, match_in;
   logic [IW-1:0]          midx_ff, midx_in;
   slot_type               rec_ff, rec_in;
   logic                   bfound_ff, bfound_in;
   logic [IW-1:0]          bidx_ff, bidx_in;
   logic [32:0]            bover_ff, bover_in;
   slot_type               brec_ff, brec_in;
   logic [4:0]             fire_cnt_ff, fire_cnt_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic          ram_wr_en, ram_rd_en;
   logic [IW-1:0] ram_wr_addr, ram_rd_addr;
   slot_type      ram_wr_data, rd_slot;
   logic [SW-1:0] ram_rd_data;
   logic [IW-1:0] free_idx;
   logic [32:0]   over;
   logic          scan_end;
   logic          cur_valid;

   mtm_ram #(
      .WIDTH  (SW),
      .DEPTH  (MAX_TIMERS),
      .ADDR_W (IW)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_slot    = slot_type'(ram_rd_data);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;
   assign scan_end   = (cnt_ff == LAST_CNT);
   assign cur_valid  = dok_ff && valid_ff[didx_ff];
   assign over       = rd_slot.elapsed - {1'b0, rd_slot.duration};

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      dok_in        = dok_ff;
      didx_in       = didx_ff;
      cmd_in        = cmd_ff;
      valid_in      = valid_ff;
      done_in       = done_ff;
      match_in      = match_ff;
      midx_in       = midx_ff;
      rec_in        = rec_ff;
      bfound_in     = bfound_ff;
      bidx_in       = bidx_ff;
      bover_in      = bover_ff;
      brec_in       = brec_ff;
      fire_cnt_in   = fire_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      q_pop         = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = didx_ff;
      ram_wr_data   = rd_slot;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cnt_ff[IW-1:0];

      // scan step shared by the look-up, increment and select passes
      if (state_ff == ST_LOOK || state_ff == ST_INC || state_ff == ST_SEL) begin
         if (!scan_end) begin
            ram_rd_en = 1'b1;
            cnt_in    = cnt_ff + CW'(1);
            dok_in    = 1'b1;
            didx_in   = cnt_ff[IW-1:0];
         end else begin
            dok_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               cmd_in      = q_entry.word;
               cnt_in      = '0;
               dok_in      = 1'b0;
               match_in    = 1'b0;
               done_in     = '0;
               fire_cnt_in = '0;
               state_in    = q_entry.is_tick ? ST_INC : ST_LOOK;
            end
         end
         ST_LOOK: begin
            // keep the first valid slot holding the id
            if (cur_valid && !match_ff && rd_slot.id == cmd_ff.timer_id) begin
               match_in = 1'b1;
               midx_in  = didx_ff;
               rec_in   = rd_slot;
            end
            if (scan_end) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_word_in            = '0;
            rsp_word_in.event_kind = KIND_CMD_DONE;
            rsp_word_in.last_of_run = 1'b1;
            rsp_strobe_in          = 1'b1;
            ram_wr_addr            = midx_ff;
            case (cmd_ff.command)
               CMD_START: begin
                  if (&valid_ff) begin
                     rsp_word_in.status = STAT_FULL;
                  end else begin
                     ram_wr_en            = 1'b1;
                     ram_wr_addr          = match_ff ? midx_ff : free_idx;
                     ram_wr_data.id       = cmd_ff.timer_id;
                     ram_wr_data.duration = cmd_ff.duration;
                     ram_wr_data.elapsed  = '0;
                     ram_wr_data.periodic = cmd_ff.cyclic;
                     valid_in[ram_wr_addr] = 1'b1;
                  end
               end
               CMD_STOP: begin
                  if (!match_ff) begin
                     rsp_word_in.status = STAT_NOTFOUND;
                  end else begin
                     valid_in[midx_ff] = 1'b0;
                  end
               end
               CMD_RESTART: begin
                  if (!match_ff) begin
                     rsp_word_in.status = STAT_NOTFOUND;
                  end else begin
                     ram_wr_en           = 1'b1;
                     ram_wr_data         = rec_ff;
                     ram_wr_data.elapsed = '0;
                  end
               end
               CMD_SETPER: begin
                  if (!match_ff) begin
                     rsp_word_in.status = STAT_NOTFOUND;
                  end else begin
                     ram_wr_en            = 1'b1;
                     ram_wr_data          = rec_ff;
                     ram_wr_data.periodic = cmd_ff.cyclic;
                  end
               end
               CMD_QUERY: begin
                  rsp_word_in.is_active = match_ff;
               end
               default: begin
               end
            endcase
            state_in = ST_IDLE;
         end
         ST_INC: begin
            // advance elapsed count of each live timer, saturating
            if (cur_valid) begin
               ram_wr_en = 1'b1;
               if (!(&rd_slot.elapsed)) begin
                  ram_wr_data.elapsed = rd_slot.elapsed + 33'd1;
               end
            end
            if (scan_end) begin
               state_in  = ST_SEL;
               cnt_in    = '0;
               dok_in    = 1'b0;
               bfound_in = 1'b0;
            end
         end
         ST_SEL: begin
            // pick the most overdue expired timer, lowest slot on ties
            if (cur_valid && !done_ff[didx_ff] &&
                rd_slot.elapsed >= {1'b0, rd_slot.duration}) begin
               if (!bfound_ff || over > bover_ff) begin
                  bfound_in = 1'b1;
                  bidx_in   = didx_ff;
                  bover_in  = over;
                  brec_in   = rd_slot;
               end
            end
            // close the tick once the expiry budget is spent or no expired timer is left
            if (scan_end) begin
               state_in = (bfound_in && fire_cnt_ff != 5'(MAX_EXPIRIES)) ?
                          ST_FIRE : ST_TEND;
            end
         end
         ST_FIRE: begin
            rsp_strobe_in              = 1'b1;
            rsp_word_in                = '0;
            rsp_word_in.event_kind     = KIND_EXPIRY;
            rsp_word_in.event_timer_id = brec_ff.id;
            rsp_word_in.event_cyclic   = brec_ff.periodic;
            done_in[bidx_ff]           = 1'b1;
            fire_cnt_in                = fire_cnt_ff + 5'd1;
            ram_wr_addr                = bidx_ff;
            if (brec_ff.periodic) begin
               ram_wr_en           = 1'b1;
               ram_wr_data         = brec_ff;
               ram_wr_data.elapsed = '0;
            end else begin
               valid_in[bidx_ff] = 1'b0;
            end
            state_in  = ST_SEL;
            cnt_in    = '0;
            dok_in    = 1'b0;
            bfound_in = 1'b0;
         end
         ST_TEND: begin
            rsp_strobe_in           = 1'b1;
            rsp_word_in             = '0;
            rsp_word_in.event_kind  = KIND_TICK_DONE;
            rsp_word_in.last_of_run = 1'b1;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         dok_ff        <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         dok_ff        <= dok_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload and scan bookkeeping
   always_ff @(posedge clock) begin
      didx_ff     <= didx_in;
      cmd_ff      <= cmd_in;
      done_ff     <= done_in;
      match_ff    <= match_in;
      midx_ff     <= midx_in;
      rec_ff      <= rec_in;
      bfound_ff   <= bfound_in;
      bidx_ff     <= bidx_in;
      bover_ff    <= bover_in;
      brec_ff     <= brec_in;
      fire_cnt_ff <= fire_cnt_in;
      rsp_word_ff <= rsp_word_in;
   end
endmodule

// ===== rtl/core/multi_timer_manager.sv =====
// Top level of the timer table: front-end command queue plus scanning back end.
// Depends on mtm_pkg, mtm_front, mtm_back and mtm_ram.
//
// Usage:
//   Request channel: a word (command, timer_id, duration, cyclic) is taken on a
//   clock edge where start is high and busy is low. Two words can be queued
//   ahead of the one in work; busy rises when the queue is full.
//   Result channel: each result word shows on rsp_word for one cycle with
//   rsp_strobe high. last_of_run marks the final result of a request.
//   Commands give one result, after one slot-memory scan and an update step.
//   A tick makes one increment scan, then one select scan per expiry and a
//   closing scan. During a scan the single read port of the slot memory
//   reads one slot per cycle.
//   Reset empties the table and the queue; slot contents need no clearing.
//   The receiver cannot stall: results are strobed once and not held.
module multi_timer_manager #(
   parameter int MAX_TIMERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mtm_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output mtm_pkg::rsp_word_type rsp_word
);
   import mtm_pkg::*;

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   mtm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   mtm_back #(
      .MAX_TIMERS (MAX_TIMERS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );
endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for multi_timer_manager: command words in, result words out.
// Depends on mtm_pkg and the RTL under rtl/core; an internal slot-table predictor
// computes every expected result word.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mtm_pkg::*;

   localparam int NUM_SLOTS = 16;
   localparam int MAX_EXPIRIES = 16;
   localparam logic [32:0] ELAPSED_SAT = 33'h1_FFFF_FFFF;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_word_type req_word;
   logic rsp_strobe;
   rsp_word_type rsp_word;

   multi_timer_manager #(.MAX_TIMERS(NUM_SLOTS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   // predictor copy of the timer table
   logic        tbl_valid [NUM_SLOTS];
   logic [15:0] tbl_id [NUM_SLOTS];
   logic [31:0] tbl_dur [NUM_SLOTS];
   logic [32:0] tbl_elapsed [NUM_SLOTS];
   logic        tbl_periodic [NUM_SLOTS];

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int words_sent = 0;
   int expiries_seen = 0;
   int results_seen = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_word_type make_rsp(logic [1:0] kind, logic [1:0] stat,
                                             logic [15:0] id, logic cyc,
                                             logic act, logic last);
      rsp_word_type r;
      r.event_kind = kind;
      r.status = stat;
      r.event_timer_id = id;
      r.event_cyclic = cyc;
      r.is_active = act;
      r.last_of_run = last;
      return r;
   endfunction

   // apply one accepted word to the table and queue its results
   task automatic predict_timer_word(req_word_type w);
      int found;
      int count;
      int best;
      int n;
      logic [32:0] best_over;
      logic [32:0] over;
      logic done [NUM_SLOTS];
      logic [1:0] stat;
      logic act;
      found = -1;
      count = 0;
      stat = STAT_OK;
      act = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (tbl_valid[i]) count++;
         if (found < 0 && tbl_valid[i] && tbl_id[i] == w.timer_id) found = i;
      end
      case (w.command)
         CMD_START: begin
            if (count >= NUM_SLOTS) begin
               stat = STAT_FULL;
            end else begin
               if (found < 0)
                  for (int i = NUM_SLOTS - 1; i >= 0; i--)
                     if (!tbl_valid[i]) found = i;
               tbl_valid[found] = 1'b1;
               tbl_id[found] = w.timer_id;
               tbl_dur[found] = w.duration;
               tbl_elapsed[found] = '0;
               tbl_periodic[found] = w.cyclic;
            end
         end
         CMD_STOP: begin
            if (found < 0) stat = STAT_NOTFOUND;
            else tbl_valid[found] = 1'b0;
         end
         CMD_RESTART: begin
            if (found < 0) stat = STAT_NOTFOUND;
            else tbl_elapsed[found] = '0;
         end
         CMD_SETPER: begin
            if (found < 0) stat = STAT_NOTFOUND;
            else tbl_periodic[found] = w.cyclic;
         end
         CMD_QUERY: act = (found >= 0);
         CMD_TICK: begin
            // advance every live timer, saturating
            for (int i = 0; i < NUM_SLOTS; i++) begin
               done[i] = 1'b0;
               if (tbl_valid[i] && tbl_elapsed[i] != ELAPSED_SAT)
                  tbl_elapsed[i] = tbl_elapsed[i] + 33'd1;
            end
            // emit expiries, most overdue first, ties to the lowest slot
            n = 0;
            best = 0;
            while (n < MAX_EXPIRIES && best >= 0) begin
               best = -1;
               best_over = '0;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (tbl_valid[i] && !done[i] && tbl_elapsed[i] >= {1'b0, tbl_dur[i]}) begin
                     over = tbl_elapsed[i] - {1'b0, tbl_dur[i]};
                     if (best < 0 || over > best_over) begin
                        best = i;
                        best_over = over;
                     end
                  end
               end
               if (best >= 0) begin
                  done[best] = 1'b1;
                  expected_rsp.push_back(make_rsp(KIND_EXPIRY, STAT_OK, tbl_id[best],
                                                  tbl_periodic[best], 1'b0, 1'b0));
                  n++;
                  if (tbl_periodic[best]) tbl_elapsed[best] = '0;
                  else tbl_valid[best] = 1'b0;
               end
            end
            expected_rsp.push_back(make_rsp(KIND_TICK_DONE, STAT_OK, '0, 1'b0, 1'b0, 1'b1));
            return;
         end
         default: ;
      endcase
      expected_rsp.push_back(make_rsp(KIND_CMD_DONE, stat, '0, 1'b0, act, 1'b1));
   endtask

   // driver: hold a word on the port until busy is low at an edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_word <= '0;
      end else if (start && !busy) begin
         predict_timer_word(req_word);
         words_sent++;
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_word <= pending_words.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_words.size() > 0
                   && $urandom_range(99) >= send_idle_pct) begin
         req_word <= pending_words.pop_front();
         start <= 1'b1;
      end
   end

   // monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type exp_rsp;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (rsp_word.event_kind == KIND_EXPIRY) expiries_seen++;
         if (expected_rsp.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            error_count++;
         end else begin
            exp_rsp = expected_rsp.pop_front();
            if (rsp_word.event_kind !== exp_rsp.event_kind) begin
               $error("event_kind expected %0d got %0d", exp_rsp.event_kind,
                      rsp_word.event_kind);
               error_count++;
            end
            if (rsp_word.status !== exp_rsp.status) begin
               $error("status expected %0d got %0d", exp_rsp.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.event_timer_id !== exp_rsp.event_timer_id) begin
               $error("event_timer_id expected %0d got %0d", exp_rsp.event_timer_id,
                      rsp_word.event_timer_id);
               error_count++;
            end
            if (rsp_word.event_cyclic !== exp_rsp.event_cyclic) begin
               $error("event_cyclic expected %0d got %0d", exp_rsp.event_cyclic,
                      rsp_word.event_cyclic);
               error_count++;
            end
            if (rsp_word.is_active !== exp_rsp.is_active) begin
               $error("is_active expected %0d got %0d", exp_rsp.is_active,
                      rsp_word.is_active);
               error_count++;
            end
            if (rsp_word.last_of_run !== exp_rsp.last_of_run) begin
               $error("last_of_run expected %0d got %0d", exp_rsp.last_of_run,
                      rsp_word.last_of_run);
               error_count++;
            end
         end
      end
   end

   function automatic req_word_type timer_cmd(logic [2:0] cmd, logic [15:0] id,
                                              logic [31:0] dur, logic cyc);
      req_word_type w;
      w.command = cmd;
      w.timer_id = id;
      w.duration = dur;
      w.cyclic = cyc;
      return w;
   endfunction

   // random word: ids from a small pool so commands hit live timers
   function automatic req_word_type random_word();
      logic [2:0] cmd;
      logic [15:0] id;
      logic [31:0] dur;
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) cmd = CMD_TICK;
      else if (pick < 55) cmd = CMD_START;
      else if (pick < 65) cmd = CMD_STOP;
      else if (pick < 73) cmd = CMD_RESTART;
      else if (pick < 81) cmd = CMD_SETPER;
      else if (pick < 94) cmd = CMD_QUERY;
      else cmd = 3'($urandom_range(7));
      if ($urandom_range(9) == 0) id = 16'($urandom);
      else id = 16'($urandom_range(20));
      pick = $urandom_range(9);
      if (pick < 7) dur = $urandom_range(4);
      else if (pick < 9) dur = $urandom;
      else dur = 32'hFFFF_FFFF;
      return timer_cmd(cmd, id, dur, 1'($urandom));
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || start || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every command, extremes, full table, zero duration, unused codes
      pending_words.push_back(timer_cmd(CMD_QUERY, 16'hFFFF, '0, 1'b0));
      pending_words.push_back(timer_cmd(CMD_STOP, 16'h0000, '0, 1'b0));
      pending_words.push_back(timer_cmd(CMD_RESTART, 16'hFFFF, '0, 1'b1));
      pending_words.push_back(timer_cmd(CMD_SETPER, 16'h1234, '0, 1'b1));
      for (int i = 0; i < NUM_SLOTS; i++)
         pending_words.push_back(timer_cmd(CMD_START, 16'(i * 4369),
                                           (i < 2) ? 32'd0 : 32'hFFFF_FFFF, i[0]));
      pending_words.push_back(timer_cmd(CMD_START, 16'h0000, 32'd5, 1'b1));
      pending_words.push_back(timer_cmd(CMD_START, 16'hABCD, 32'd5, 1'b1));
      pending_words.push_back(timer_cmd(CMD_TICK, '0, '0, 1'b0));
      pending_words.push_back(timer_cmd(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      pending_words.push_back(timer_cmd(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      pending_words.push_back(timer_cmd(3'd7, '0, '0, 1'b0));
      send_idle_pct = 14;
      wait_drained();

      // clear the table for the random part
      for (int i = 0; i < NUM_SLOTS; i++)
         pending_words.push_back(timer_cmd(CMD_STOP, 16'(i * 4369), '0, 1'b0));
      wait_drained();

      // random: sender idles rarely, then often, then never
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 75 : 0;
         for (int k = 0; k < 36; k++) pending_words.push_back(random_word());
         wait_drained();
      end

      $display("Sent %0d command words, checked %0d results including %0d expiries.",
               words_sent, results_seen, expiries_seen);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
